// ===== src/point_mass_lens_warp_macros.svh =====
// Assertion macros shared by the lens warp RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef POINT_MASS_LENS_WARP_MACROS_SVH
`define POINT_MASS_LENS_WARP_MACROS_SVH
`ifndef ASSERT_OFF
// check sampled on the rising clock edge, masked while reset is high
`define PMLW_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("lens warp assertion failed");
// check sampled on the rising clock edge, live during reset
`define PMLW_ASSERT_RST(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("lens warp reset assertion failed");
`else
`define PMLW_ASSERT(lbl, clk_s, rst_s, prop)
`define PMLW_ASSERT_RST(lbl, clk_s, prop)
`endif
`endif

// ===== src/pmlw_pkg.sv =====
// Shared constants and types of the point-mass lens warp.
// No dependencies; imported by every module of the block.
package pmlw_pkg;

  localparam int IMG_SIZE  = 256;
  localparam int ROW_W     = 8;
  localparam int COL_W     = 9;
  localparam int CHI_W     = 7;
  localparam int ER_W      = 9;
  localparam int AO_W      = 40;
  localparam int CFG_W     = 40;

  // divider geometry: 64-bit dividend, 54-bit divisor, 41 quotient bits
  localparam int NUM_W     = 64;
  localparam int DEN_W     = 54;
  localparam int Q_W       = 41;
  localparam int DIV_STEPS = Q_W;
  localparam int HI_W      = NUM_W - Q_W;
  localparam int LANES     = 3;

  // signed Q16 sums and rounded magnitudes
  localparam int SUM_W     = 44;
  localparam int RND_W     = SUM_W + 1 - 16;

  localparam logic [Q_W-1:0] TERM_CAP = Q_W'(1) << (Q_W - 1);

  typedef enum logic [1:0] {
    REG_CHI = 2'd0,
    REG_ER  = 2'd1,
    REG_AO  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [CHI_W-1:0] chi;
    logic [ER_W-1:0]  er;
    logic [AO_W-1:0]  ao;
  } cfg_t;

  // per-item data that rides alongside the dividers
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             p_neg;
    logic             q_neg;
    logic             ok;
  } side_t;

  typedef struct packed {
    logic [NUM_W-1:0] n1;
    logic [NUM_W-1:0] n2;
    logic [NUM_W-1:0] n3;
    logic [DEN_W-1:0] d1;
    logic [DEN_W-1:0] d23;
  } div_ops_t;

  typedef struct packed {
    logic [Q_W-1:0] q1;
    logic [Q_W-1:0] q2;
    logic [Q_W-1:0] q3;
    logic           ovf1;
    logic           ovf2;
    logic           ovf3;
  } quot_t;

endpackage

// ===== src/point_mass_lens_warp.sv =====
// Top level of the point-mass lens warp: config registers, stall control,
// front end, divider pipeline, back end. Uses pmlw_pkg and submodules.
//
//  channel  | signals                         | content
//  ---------+---------------------------------+------------------------------
//  s        | s_tvalid s_tready s_tdata[23:0] | pixel_row, pixel_col
//  m        | m_tvalid m_tready m_tdata[23:0] | source_row, source_col
//           | m_tuser                         | in_range
//  cfg      | cfg_we cfg_index cfg_data[39:0] | chi, Einstein radius, offset
//
// One item per clock while m is not stalled; items pass the front end, divider chain and back end in turn.
// The divider chain, one quotient bit per stage, sets the latency.
// Reset clears valid bits and loads chi 50, radius 12, offset 0.
// A stall on m freezes every stage at once; s_tready follows it.
module point_mass_lens_warp (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] pixel_row, [16:8] pixel_col
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] source_row, [16:8] source_col
  output logic        m_tuser,   // [0] in_range
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [pmlw_pkg::CFG_W-1:0] cfg_data
);
  import pmlw_pkg::*;

  cfg_t     cfg;
  logic     ce;
  logic     pv, dv;
  side_t    pside, dside;
  div_ops_t ops;
  quot_t    quot;
  logic [7:0] src_row;
  logic [8:0] src_col;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chi <= CHI_W'(50);
      cfg.er  <= ER_W'(12);
      cfg.ao  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHI: cfg.chi <= cfg_data[CHI_W-1:0];
        REG_ER:  cfg.er  <= cfg_data[ER_W-1:0];
        REG_AO:  cfg.ao  <= cfg_data[AO_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless the output item is held
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  pmlw_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (s_tvalid),
    .pixel_row (s_tdata[7:0]),
    .pixel_col (s_tdata[16:8]),
    .cfg       (cfg),
    .out_valid (pv),
    .out_side  (pside),
    .out_ops   (ops)
  );

  pmlw_div u_div (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (pv),
    .in_side   (pside),
    .in_ops    (ops),
    .out_valid (dv),
    .out_side  (dside),
    .out_q     (quot)
  );

  pmlw_post u_post (
    .clk        (clk),
    .rst        (rst),
    .ce         (ce),
    .in_valid   (dv),
    .in_side    (dside),
    .in_q       (quot),
    .out_valid  (m_tvalid),
    .source_row (src_row),
    .source_col (src_col),
    .in_range   (m_tuser)
  );

  assign m_tdata = {7'b0, src_col, src_row};

endmodule

// ===== src/pmlw_prep.sv =====
// Front end: pixel offsets, squares and products that form the three
// dividends and two divisors. Three register stages. Uses pmlw_pkg.
module pmlw_prep (
  input  logic              clk,
  input  logic              rst,
  input  logic              ce,
  input  logic              in_valid,
  input  logic [7:0]        pixel_row,
  input  logic [8:0]        pixel_col,
  input  pmlw_pkg::cfg_t    cfg,
  output logic              out_valid,
  output pmlw_pkg::side_t   out_side,
  output pmlw_pkg::div_ops_t out_ops
);
  import pmlw_pkg::*;

  // stage 1 registers
  logic             v1;
  logic [ROW_W-1:0] row1;
  logic [COL_W-1:0] col1;
  logic             pneg1, qneg1, chi_nz1;
  logic [9:0]       p2m1;
  logic [8:0]       q2m1;
  logic [13:0]      c2_1;
  logic [17:0]      e2_1;

  // stage 2 registers
  logic             v2;
  logic [ROW_W-1:0] row2;
  logic [COL_W-1:0] col2;
  logic             pneg2, qneg2, chi_nz2;
  logic [9:0]       p2m2;
  logic [8:0]       q2m2;
  logic [13:0]      c2_2;
  logic [19:0]      s4_2;
  logic [31:0]      e10k2;
  logic [32:0]      e20k2;
  logic [33:0]      cal2, cah2;

  // stage 3 registers
  logic             v3;
  side_t            side3;
  div_ops_t         ops3;

  logic [9:0] pdiff, qdiff, row_x2;
  logic       pneg_c, qneg_c;

  // doubled offsets from the image center
  always_comb begin
    row_x2 = {1'b0, pixel_row, 1'b0};
    pneg_c = ({1'b0, pixel_col} < 10'(IMG_SIZE));
    qneg_c = (row_x2 > 10'(IMG_SIZE));
    pdiff  = pneg_c ? (10'(IMG_SIZE) - {1'b0, pixel_col})
                    : ({1'b0, pixel_col} - 10'(IMG_SIZE));
    qdiff  = qneg_c ? (row_x2 - 10'(IMG_SIZE)) : (10'(IMG_SIZE) - row_x2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (ce) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // stage 1: offsets and small squares
  always_ff @(posedge clk) begin
    if (ce) begin
      row1    <= pixel_row;
      col1    <= pixel_col;
      pneg1   <= pneg_c;
      qneg1   <= qneg_c;
      p2m1    <= {pdiff[8:0], 1'b0};
      q2m1    <= qdiff[8:0];
      c2_1    <= 14'(cfg.chi) * 14'(cfg.chi);
      e2_1    <= 18'(cfg.er) * 18'(cfg.er);
      chi_nz1 <= (cfg.chi != '0);
    end
  end

  // stage 2: radius squared, scaled E^2, split c^2 * A
  always_ff @(posedge clk) begin
    if (ce) begin
      row2    <= row1;
      col2    <= col1;
      pneg2   <= pneg1;
      qneg2   <= qneg1;
      chi_nz2 <= chi_nz1;
      p2m2    <= p2m1;
      q2m2    <= q2m1;
      c2_2    <= c2_1;
      s4_2    <= 20'(p2m1) * 20'(p2m1) + 20'(q2m1) * 20'(q2m1);
      e10k2   <= 32'(e2_1) * 32'd10000;
      e20k2   <= 33'(e2_1) * 33'd20000;
      cal2    <= 34'(c2_1) * 34'(cfg.ao[19:0]);
      cah2    <= 34'(c2_1) * 34'(cfg.ao[39:20]);
    end
  end

  // stage 3: dividends and divisors
  always_ff @(posedge clk) begin
    if (ce) begin
      side3.row   <= row2;
      side3.col   <= col2;
      side3.p_neg <= pneg2;
      side3.q_neg <= qneg2;
      side3.ok    <= chi_nz2 && (cfg.ao != '0) && (s4_2 != '0);
      ops3.n1     <= {e10k2, 32'b0};
      ops3.n2     <= {5'b0, 43'(e20k2) * 43'(p2m2), 16'b0};
      ops3.n3     <= {6'b0, 42'(e20k2) * 42'(q2m2), 16'b0};
      ops3.d1     <= {cah2[33:0], 20'b0} + {20'b0, cal2};
      ops3.d23    <= {20'b0, 34'(c2_2) * 34'(s4_2)};
    end
  end

  assign out_valid = v3;
  assign out_side  = side3;
  assign out_ops   = ops3;

endmodule

// ===== src/pmlw_div.sv =====
// Three restoring dividers in lockstep, one quotient bit per stage.
// Carries the per-item side data. Uses pmlw_pkg and the assertion macros.
`include "point_mass_lens_warp_macros.svh"
module pmlw_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               ce,
  input  logic               in_valid,
  input  pmlw_pkg::side_t    in_side,
  input  pmlw_pkg::div_ops_t in_ops,
  output logic               out_valid,
  output pmlw_pkg::side_t    out_side,
  output pmlw_pkg::quot_t    out_q
);
  import pmlw_pkg::*;

  logic             valid [0:DIV_STEPS];
  side_t            side  [0:DIV_STEPS];
  logic [DEN_W-1:0] rem   [0:DIV_STEPS][0:LANES-1];
  logic [DEN_W-1:0] dvs   [0:DIV_STEPS][0:LANES-1];
  logic [Q_W-1:0]   nlo   [0:DIV_STEPS][0:LANES-1];
  logic [Q_W-1:0]   quo   [0:DIV_STEPS][0:LANES-1];
  logic             ovf   [0:DIV_STEPS][0:LANES-1];

  logic [NUM_W-1:0] n_in [0:LANES-1];
  logic [DEN_W-1:0] d_in [0:LANES-1];

  assign n_in[0] = in_ops.n1;
  assign n_in[1] = in_ops.n2;
  assign n_in[2] = in_ops.n3;
  assign d_in[0] = in_ops.d1;
  assign d_in[1] = in_ops.d23;
  assign d_in[2] = in_ops.d23;

  // valid bits and side data through all stages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_STEPS; k++) valid[k] <= 1'b0;
    end else if (ce) begin
      valid[0] <= in_valid;
      for (int k = 1; k <= DIV_STEPS; k++) valid[k] <= valid[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      side[0] <= in_side;
      for (int k = 1; k <= DIV_STEPS; k++) side[k] <= side[k-1];
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    // entry stage: top dividend bits seed the remainder; quotient
    // overflow past Q_W bits is flagged here
    always_ff @(posedge clk) begin
      if (ce) begin
        rem[0][l] <= DEN_W'(n_in[l][NUM_W-1:Q_W]);
        ovf[0][l] <= (DEN_W'(n_in[l][NUM_W-1:Q_W]) >= d_in[l]);
        nlo[0][l] <= n_in[l][Q_W-1:0];
        quo[0][l] <= '0;
        dvs[0][l] <= d_in[l];
      end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      logic           ge;

      // one shift, compare and subtract
      always_comb begin
        trial = {rem[k-1][l], nlo[k-1][l][Q_W-1]};
        diff  = trial - {1'b0, dvs[k-1][l]};
        ge    = (trial >= {1'b0, dvs[k-1][l]});
      end

      always_ff @(posedge clk) begin
        if (ce) begin
          rem[k][l] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
          nlo[k][l] <= {nlo[k-1][l][Q_W-2:0], 1'b0};
          quo[k][l] <= {quo[k-1][l][Q_W-2:0], ge};
          ovf[k][l] <= ovf[k-1][l];
          dvs[k][l] <= dvs[k-1][l];
        end
      end
    end
  end

  assign out_valid  = valid[DIV_STEPS];
  assign out_side   = side[DIV_STEPS];
  assign out_q.q1   = quo[DIV_STEPS][0];
  assign out_q.q2   = quo[DIV_STEPS][1];
  assign out_q.q3   = quo[DIV_STEPS][2];
  assign out_q.ovf1 = ovf[DIV_STEPS][0];
  assign out_q.ovf2 = ovf[DIV_STEPS][1];
  assign out_q.ovf3 = ovf[DIV_STEPS][2];

  // remainder stays below the divisor at every stage of a live item without overflow
  for (genvar k = 0; k <= DIV_STEPS; k++) begin : g_chk
    `PMLW_ASSERT(a_rem_l0, clk, rst, valid[k] && !ovf[k][0] |-> rem[k][0] < dvs[k][0])
    `PMLW_ASSERT(a_rem_l1, clk, rst, valid[k] && !ovf[k][1] |-> rem[k][1] < dvs[k][1])
    `PMLW_ASSERT(a_rem_l2, clk, rst, valid[k] && !ovf[k][2] |-> rem[k][2] < dvs[k][2])
  end

endmodule

// ===== src/pmlw_post.sv =====
// Back end: saturate quotients, form Q16 source position, round half
// away from zero, range check. Two stages. Uses pmlw_pkg and macros.
`include "point_mass_lens_warp_macros.svh"
module pmlw_post (
  input  logic             clk,
  input  logic             rst,
  input  logic             ce,
  input  logic             in_valid,
  input  pmlw_pkg::side_t  in_side,
  input  pmlw_pkg::quot_t  in_q,
  output logic             out_valid,
  output logic [7:0]       source_row,
  output logic [8:0]       source_col,
  output logic             in_range
);
  import pmlw_pkg::*;

  logic [Q_W-1:0]   t1, t2, t3;
  logic [SUM_W-1:0] colq_c, rowq_c;

  logic             v1;
  logic             ok1;
  logic [SUM_W-1:0] colq1, rowq1;

  logic             cneg, rneg;
  logic [SUM_W-1:0] cmag, rmag;
  logic [RND_W-1:0] cm, rm;
  logic             all_ok;

  // clamp each term at the cap
  always_comb begin
    t1 = (in_q.ovf1 || in_q.q1 > TERM_CAP) ? TERM_CAP : in_q.q1;
    t2 = (in_q.ovf2 || in_q.q2 > TERM_CAP) ? TERM_CAP : in_q.q2;
    t3 = (in_q.ovf3 || in_q.q3 > TERM_CAP) ? TERM_CAP : in_q.q3;
    colq_c = {19'b0, in_side.col, 16'b0} + SUM_W'(t1);
    colq_c = in_side.p_neg ? (colq_c + SUM_W'(t2)) : (colq_c - SUM_W'(t2));
    rowq_c = {20'b0, in_side.row, 16'b0};
    rowq_c = in_side.q_neg ? (rowq_c - SUM_W'(t3)) : (rowq_c + SUM_W'(t3));
  end

  // stage 1: signed Q16 positions
  always_ff @(posedge clk) begin
    if (ce) begin
      colq1 <= colq_c;
      rowq1 <= rowq_c;
      ok1   <= in_side.ok;
    end
  end

  // round magnitude, then bound check
  always_comb begin
    cneg   = colq1[SUM_W-1];
    rneg   = rowq1[SUM_W-1];
    cmag   = cneg ? (-colq1) : colq1;
    rmag   = rneg ? (-rowq1) : rowq1;
    cm     = RND_W'(({1'b0, cmag} + (SUM_W+1)'(32768)) >> 16);
    rm     = RND_W'(({1'b0, rmag} + (SUM_W+1)'(32768)) >> 16);
    all_ok = ok1
          && (cneg ? (cm == '0) : (cm < RND_W'(2 * IMG_SIZE)))
          && (rneg ? (rm == '0) : (rm < RND_W'(IMG_SIZE)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  // stage 2: output register
  always_ff @(posedge clk) begin
    if (ce) begin
      in_range   <= all_ok;
      source_col <= all_ok ? cm[8:0] : '0;
      source_row <= all_ok ? rm[7:0] : '0;
    end
  end

  `PMLW_ASSERT(a_zero_out, clk, rst, out_valid && !in_range |-> source_row == '0 && source_col == '0)
  `PMLW_ASSERT_RST(a_rst_clear, clk, rst |=> !out_valid && !v1)
  `PMLW_ASSERT(a_bad_div, clk, rst, v1 && !ok1 && ce |=> out_valid && !in_range)

endmodule
